/* hw/rtl/hrd_pkg.sv */
// ----------------------------------------------------------------------------
// hrd_pkg
// Shared types and constants for the heartbeat rate detector: the item
// layouts of both channels, the default window length and the rate constants.
// ----------------------------------------------------------------------------
package hrd_pkg;

    // Default number of readings held in the averaging window.
    localparam int HRD_WINDOW = 16;

    // Reset value of the rise limit register.
    localparam logic [7:0] HRD_RISE_LIMIT_RST = 8'd4;

    // Rate numerator: tenths of a beat per minute over a weighted sum of
    // intervals in ms, weights 4, 3 and 3 out of ten.
    localparam int          HRD_NUM_W    = 23;
    localparam logic [22:0] HRD_RATE_NUM = 23'd6000000;

    // Width of the weighted interval sum, at most 655350.
    localparam int HRD_DIV_W = 20;

    // One input item.
    typedef struct packed {
        logic [9:0]  reading;
        logic [31:0] time_ms;
    } hrd_in_t;

    // One result item.
    typedef struct packed {
        logic        beat;
        logic [15:0] rate_tenths;
        logic [15:0] interval_ms;
        logic        rising_now;
    } hrd_out_t;

endpackage

/* hw/rtl/heartbeat_rate_detector.sv */
// Each item passes through the CALC state and, when it causes a beat, through the DIV state before DONE.
// A new item is taken only in the idle state, after the last result has been loaded; the 23-step
// restoring divider that forms the rate runs only for an item that causes a beat.
// The ring memory has one port pair and is read in the cycle after acceptance.
// Reset clears all control state; ring entries not yet written since reset count as zero until the ring wraps.
// ----------------------------------------------------------------------------
// heartbeat_rate_detector
// Keeps a ring of recent readings and their running sum in a synchronous
// memory, counts consecutive rises of the sum, flags a beat and works out the
// beat rate from the last three beat intervals with a bit-serial divider.
// ----------------------------------------------------------------------------
module heartbeat_rate_detector #(
    parameter int WINDOW = hrd_pkg::HRD_WINDOW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    output logic            sample_ready,
    input  hrd_pkg::hrd_in_t  sample,
    output logic            result_valid,
    input  logic            result_ready,
    output hrd_pkg::hrd_out_t result,
    input  logic            rise_limit_we,
    input  logic [7:0]      rise_limit_wdata
);
    import hrd_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int SUM_W = $clog2(WINDOW * 1023 + 1);
    localparam int BIT_W = $clog2(HRD_NUM_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    hrd_in_t              item_reg;
    logic [9:0]           sample_ring [WINDOW];
    logic [9:0]           rd_data_reg;
    logic [IDX_W-1:0]     write_index_reg;
    logic                 wrapped_reg;
    logic [SUM_W-1:0]     window_sum_reg;
    logic [SUM_W-1:0]     previous_sum_reg;
    logic [7:0]           rise_run_reg;
    logic                 rising_reg;
    logic [31:0]          prev_beat_time_reg;
    logic [15:0]          interval0_reg;
    logic [15:0]          interval1_reg;
    logic [15:0]          rate_hold_reg;
    logic                 beat_reg;
    logic [7:0]           rise_limit_reg;
    logic [HRD_DIV_W-1:0] divisor_reg;
    logic [HRD_DIV_W-1:0] rem_reg;
    logic [HRD_NUM_W-1:0] quo_reg;
    logic [BIT_W-1:0]     bit_reg;
    logic                 result_valid_reg;
    hrd_out_t             result_reg;

    logic                 accept;
    logic                 load_result;
    logic [9:0]           old_sample;
    logic [SUM_W-1:0]     sum_new;
    logic                 is_rise;
    logic [7:0]           count_inc;
    logic                 beat_now;
    logic [31:0]          time_diff;
    logic [15:0]          newest;
    logic [HRD_DIV_W-1:0] divisor_new;
    logic [HRD_DIV_W:0]   rem_shift;
    logic [HRD_DIV_W:0]   rem_sub;
    logic                 q_bit;
    logic [HRD_NUM_W-1:0] quo_next;
    logic [15:0]          rate_sat;

    // Handshake on both channels.
    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign load_result  = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Ring memory: read at acceptance, written back with the new reading.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= sample_ring[write_index_reg];
        end
        if (state_reg == ST_CALC)
        begin
            sample_ring[write_index_reg] <= item_reg.reading;
        end
    end

    // Window sum update and rise detection on the entry just read.
    always_comb
    begin
        old_sample  = wrapped_reg ? rd_data_reg : 10'd0;
        sum_new     = window_sum_reg - SUM_W'(old_sample) + SUM_W'(item_reg.reading);
        is_rise     = sum_new > previous_sum_reg;
        count_inc   = (rise_run_reg == 8'hFF) ? 8'hFF : rise_run_reg + 8'd1;
        beat_now    = is_rise && !rising_reg && (count_inc > rise_limit_reg);
        time_diff   = item_reg.time_ms - prev_beat_time_reg;
        newest      = (|time_diff[31:16]) ? 16'hFFFF : time_diff[15:0];
        divisor_new = (HRD_DIV_W'(newest) << 2)
                    + (HRD_DIV_W'(interval0_reg) << 1) + HRD_DIV_W'(interval0_reg)
                    + (HRD_DIV_W'(interval1_reg) << 1) + HRD_DIV_W'(interval1_reg);
    end

    // One restoring division step per cycle; a zero divisor gives all ones.
    always_comb
    begin
        rem_shift = {rem_reg, HRD_RATE_NUM[bit_reg]};
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        q_bit     = rem_shift >= {1'b0, divisor_reg};
        quo_next  = {quo_reg[HRD_NUM_W-2:0], q_bit};
        rate_sat  = (|quo_next[HRD_NUM_W-1:16]) ? 16'hFFFF : quo_next[15:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CALC;
            ST_CALC: state_next = beat_now ? ST_DIV : ST_DONE;
            ST_DIV:  if (bit_reg == '0) state_next = ST_DONE;
            ST_DONE: if (load_result) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and detector state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            write_index_reg    <= '0;
            wrapped_reg        <= 1'b0;
            window_sum_reg     <= '0;
            previous_sum_reg   <= '0;
            rise_run_reg       <= '0;
            rising_reg         <= 1'b0;
            prev_beat_time_reg <= '0;
            interval0_reg      <= '0;
            interval1_reg      <= '0;
            rate_hold_reg      <= '0;
            beat_reg           <= 1'b0;
            rise_limit_reg     <= HRD_RISE_LIMIT_RST;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rise_limit_we)
            begin
                rise_limit_reg <= rise_limit_wdata;
            end
            if (state_reg == ST_CALC)
            begin
                window_sum_reg   <= sum_new;
                previous_sum_reg <= sum_new;
                beat_reg         <= beat_now;
                if (write_index_reg == IDX_W'(WINDOW - 1))
                begin
                    write_index_reg <= '0;
                    wrapped_reg     <= 1'b1;
                end
                else
                begin
                    write_index_reg <= write_index_reg + 1'b1;
                end
                if (is_rise)
                begin
                    rise_run_reg <= count_inc;
                    if (beat_now)
                    begin
                        rising_reg         <= 1'b1;
                        prev_beat_time_reg <= item_reg.time_ms;
                        interval1_reg      <= interval0_reg;
                        interval0_reg      <= newest;
                    end
                end
                else
                begin
                    rise_run_reg <= '0;
                    rising_reg   <= 1'b0;
                end
            end
            if ((state_reg == ST_DIV) && (bit_reg == '0))
            begin
                rate_hold_reg <= rate_sat;
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture, divider datapath and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= sample;
        end
        if (state_reg == ST_CALC)
        begin
            divisor_reg <= divisor_new;
            rem_reg     <= '0;
            quo_reg     <= '0;
            bit_reg     <= BIT_W'(HRD_NUM_W - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= q_bit ? rem_sub[HRD_DIV_W-1:0] : rem_shift[HRD_DIV_W-1:0];
            quo_reg <= quo_next;
            bit_reg <= bit_reg - 1'b1;
        end
        if (load_result)
        begin
            result_reg.beat        <= beat_reg;
            result_reg.rate_tenths <= rate_hold_reg;
            result_reg.interval_ms <= interval0_reg;
            result_reg.rising_now  <= rising_reg;
        end
    end

endmodule

/* dv/tb_heartbeat_rate_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heartbeat_rate_detector
// Drives readings with timestamps into the heartbeat rate detector and checks
// every result against a cycle-free model of the detector kept in the bench.
// A short directed run covers the boundary cases, and random pulse trains,
// noise and time jumps follow under several rise limits and idling patterns.
// ----------------------------------------------------------------------------
module tb_heartbeat_rate_detector;

    import hrd_pkg::*;

    // Rate numerator in tenths of a beat per minute, intervals in ms.
    localparam int unsigned RATE_NUMERATOR = 6000000;
    localparam int          SETTLE_CYCLES  = 30;
    localparam int          FINAL_CYCLES   = 40;
    localparam int          QUIET_LIMIT    = 3000;

    logic       clk               = 1'b0;
    logic       rst_n             = 1'b0;
    logic       sample_valid      = 1'b0;
    logic       sample_ready;
    hrd_in_t    sample            = '0;
    logic       result_valid;
    logic       result_ready      = 1'b0;
    hrd_out_t   result;
    logic       rise_limit_we     = 1'b0;
    logic [7:0] rise_limit_wdata  = '0;

    // Items waiting to be driven and results waiting to arrive.
    hrd_in_t    queued_readings[$];
    hrd_out_t   predicted_results[$];

    int         sender_idle_pct   = 26;
    int         receiver_idle_pct = 50;
    int         mismatches        = 0;
    int         quiet_cycles      = 0;
    int         readings_queued   = 0;

    // Detector state as seen by the bench.
    logic [9:0]  ring_hist [HRD_WINDOW] = '{default: '0};
    int unsigned ring_pos       = 0;
    int unsigned run_sum        = 0;
    int unsigned last_sum       = 0;
    logic [7:0]  rise_run       = '0;
    logic        rising         = 1'b0;
    logic [31:0] prev_beat_time = '0;
    logic [15:0] newest_gap     = '0;
    logic [15:0] older_gap      = '0;
    logic [15:0] held_rate      = '0;
    logic [7:0]  beat_threshold = HRD_RISE_LIMIT_RST;

    // Stimulus generator state.
    int          gen_level      = 0;
    logic [31:0] gen_time       = '0;

    heartbeat_rate_detector DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .sample           (sample),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .result           (result),
        .rise_limit_we    (rise_limit_we),
        .rise_limit_wdata (rise_limit_wdata)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Weighted three-interval rate, saturating, with a zero divisor giving
    // the top value.
    function automatic logic [15:0] weighted_rate(input logic [15:0] i1,
                                                  input logic [15:0] i2,
                                                  input logic [15:0] i3);
        int unsigned divisor;
        int unsigned quotient;
        divisor = 4 * i1 + 3 * i2 + 3 * i3;
        if (divisor == 0)
            return 16'hFFFF;
        quotient = RATE_NUMERATOR / divisor;
        return (quotient > 65535) ? 16'hFFFF : quotient[15:0];
    endfunction

    // Advances the bench's copy of the detector by one reading and returns
    // the result it should produce.
    function automatic hrd_out_t detect_beat(input hrd_in_t s);
        hrd_out_t    r;
        int unsigned sum;
        logic [31:0] gap;
        logic [15:0] gap_sat;
        r       = '0;
        sum     = run_sum - ring_hist[ring_pos] + s.reading;
        run_sum = sum;
        ring_hist[ring_pos] = s.reading;
        if (sum > last_sum)
        begin
            if (rise_run != 8'hFF)
                rise_run = rise_run + 1'b1;
            if (!rising && rise_run > beat_threshold)
            begin
                gap            = s.time_ms - prev_beat_time;
                gap_sat        = (gap > 32'd65535) ? 16'hFFFF : gap[15:0];
                rising         = 1'b1;
                prev_beat_time = s.time_ms;
                held_rate      = weighted_rate(gap_sat, newest_gap, older_gap);
                older_gap      = newest_gap;
                newest_gap     = gap_sat;
                r.beat         = 1'b1;
            end
        end
        else
        begin
            rising   = 1'b0;
            rise_run = '0;
        end
        last_sum      = sum;
        ring_pos      = (ring_pos == HRD_WINDOW - 1) ? 0 : ring_pos + 1;
        r.rate_tenths = held_rate;
        r.interval_ms = newest_gap;
        r.rising_now  = rising;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Driver: predicts each accepted item and loads the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                predicted_results.push_back(detect_beat(sample));
            if (!sample_valid || sample_ready)
            begin
                if (queued_readings.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct)
                begin
                    sample       <= queued_readings.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
            result_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        hrd_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no prediction, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("beat", want.beat, result.beat);
                check_field("rate_tenths", want.rate_tenths, result.rate_tenths);
                check_field("interval_ms", want.interval_ms, result.interval_ms);
                check_field("rising_now", want.rising_now, result.rising_now);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_reading(input logic [9:0] level, input logic [31:0] stamp);
        hrd_in_t s;
        s.reading = level;
        s.time_ms = stamp;
        queued_readings.push_back(s);
        readings_queued++;
    endtask

    function automatic logic [31:0] next_time();
        gen_time = gen_time + $urandom_range(40, 0);
        return gen_time;
    endfunction

    // Waits until every item has been taken and answered, then idles before
    // the next phase.
    task automatic settle();
        while (queued_readings.size() != 0 || sample_valid ||
               predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rise_limit(input logic [7:0] limit);
        @(posedge clk);
        rise_limit_we    <= 1'b1;
        rise_limit_wdata <= limit;
        @(posedge clk);
        rise_limit_we    <= 1'b0;
        beat_threshold   = limit;
    endtask

    // Random traffic: mostly pulse trains that rise and fall, with bursts of
    // noise, flat stretches and jumps of the clock. An optional slow ramp
    // keeps the sum rising long enough to saturate the rise count.
    task automatic random_traffic(input int n_items, input bit with_ramp);
        int start;
        int kind;
        int n;
        int k;
        start = readings_queued;
        if (with_ramp)
        begin
            for (k = 0; k < HRD_WINDOW; k++)
                queue_reading('0, next_time());
            for (k = 0; k < 280; k++)
                queue_reading(10'(k / 8), next_time());
            gen_level = 35;
        end
        while (readings_queued - start < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                n = $urandom_range(12, 1);
                for (k = 0; k < n; k++)
                begin
                    gen_level = gen_level + $urandom_range(80, 1);
                    if (gen_level > 1023)
                        gen_level = 1023;
                    queue_reading(10'(gen_level), next_time());
                end
                n = $urandom_range(20, 1);
                for (k = 0; k < n; k++)
                begin
                    gen_level = gen_level - $urandom_range(80, 0);
                    if (gen_level < 0)
                        gen_level = 0;
                    queue_reading(10'(gen_level), next_time());
                end
            end
            else if (kind < 85)
            begin
                n = $urandom_range(8, 1);
                for (k = 0; k < n; k++)
                    queue_reading(10'($urandom_range(1023)), next_time());
            end
            else if (kind < 95)
            begin
                n = $urandom_range(10, 2);
                for (k = 0; k < n; k++)
                    queue_reading(10'(gen_level), next_time());
            end
            else
            begin
                // Clock jumps: a long gap, an arbitrary value or near the wrap.
                n = $urandom_range(2);
                if (n == 0)
                    gen_time = gen_time + $urandom_range(200000, 65536);
                else if (n == 1)
                    gen_time = $urandom();
                else
                    gen_time = 32'hFFFF_FFFF - $urandom_range(200, 0);
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] limit, input int s_pct,
                             input int r_pct, input int n_items, input bit with_ramp);
        write_rise_limit(limit);
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        @(negedge clk);
        random_traffic(n_items, with_ramp);
        settle();
    endtask

    // Reset, directed cases under the reset rise limit, then random phases.
    initial
    begin : stimulus
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Five rises at time zero: the first beat has a zero interval, so
        // all three intervals are zero and the divisor is zero.
        for (k = 1; k <= 5; k++)
            queue_reading(10'(k), '0);
        // A flat sum clears the rise count.
        queue_reading('0, '0);
        // A beat one ms later: the quotient overflows and saturates.
        for (k = 6; k <= 10; k++)
            queue_reading(10'(k), 32'd1);
        queue_reading('0, 32'd1);
        // A long gap saturates the interval.
        for (k = 0; k < 5; k++)
            queue_reading(10'd1000, 32'd100000);
        queue_reading('0, 32'd100000);
        // Beats either side of the wrap of the millisecond counter.
        for (k = 0; k < 5; k++)
            queue_reading(10'd1023, 32'hFFFF_FFFF);
        queue_reading('0, 32'hFFFF_FFFF);
        for (k = 0; k < 5; k++)
            queue_reading(10'd1023, 32'h10);
        gen_time = 32'h10;
        settle();

        run_phase(8'd0, 26, 50, 330, 1'b0);
        run_phase(8'($urandom_range(8, 2)), 50, 26, 330, 1'b0);
        run_phase(8'd255, 0, 0, 370, 1'b1);
        run_phase(8'd254, 0, 0, 370, 1'b1);

        repeat (FINAL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
